>>> design/gidt_pkg.sv
// Package for the GPIO interrupt dispatch table: beat types, command and status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package gidt_pkg;

	localparam int TABLE_SLOTS_DEF = 8;
	localparam int SLOT_INDEX_W    = 3;

	typedef enum logic [1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_SET_ENABLE = 2'd2,
		CMD_EVENT      = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_HANDLER = 3'd1,
		ST_FULL       = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_LEVEL      = 3'd4,
		ST_DEBOUNCED  = 3'd5
	} status_t;

	typedef struct packed {
		command_t    command;
		logic [15:0] line_mask;
		logic [7:0]  handler_id;
		logic        level_checked;
		logic [1:0]  wanted_level;
		logic [31:0] window_us;
		logic        turn_on;
		logic        sampled_level;
		logic [31:0] now_us;
	} item_t;

	typedef struct packed {
		status_t                   status;
		logic                      fire;
		logic [7:0]                fired_handler;
		logic [15:0]               fired_line;
		logic [SLOT_INDEX_W-1:0]   slot_index;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_EXEC = 2'd2
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

>>> design/gidt_ctrl.sv
// Controller state machine of the GPIO interrupt dispatch table.
// Depends on gidt_pkg; drives the datapath through dp_cmd_t and watches dp_stat_t.
`timescale 1ns / 1ps

module gidt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gidt_pkg::dp_stat_t stat,
	output gidt_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	import gidt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> design/gidt_datapath.sv
// Datapath of the GPIO interrupt dispatch table: slot storage, slot scan and command execution.
// Depends on gidt_pkg; sequenced by gidt_ctrl.
`timescale 1ns / 1ps

module gidt_datapath #(
	parameter int TABLE_SLOTS = gidt_pkg::TABLE_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gidt_pkg::dp_cmd_t  cmd,
	output gidt_pkg::dp_stat_t stat,
	input  gidt_pkg::item_t    item,
	output gidt_pkg::result_t  result,
	output logic              done
);
	import gidt_pkg::*;

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	// Slot table. Only the enable bits need a reset: every other field of a slot is
	// written whenever the slot becomes enabled.
	logic [TABLE_SLOTS-1:0] enabled_q;
	logic [15:0]            line_q    [TABLE_SLOTS];
	logic [7:0]             handler_q [TABLE_SLOTS];
	logic                   lvl_chk_q [TABLE_SLOTS];
	logic [1:0]             wanted_q  [TABLE_SLOTS];
	logic [31:0]            window_q  [TABLE_SLOTS];
	logic [31:0]            last_q    [TABLE_SLOTS];

	item_t            item_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             match_hit_q, free_hit_q;
	logic [IDX_W-1:0] match_idx_q, free_idx_q;
	logic [7:0]       m_handler_q;
	logic             m_lvl_chk_q;
	logic [1:0]       m_wanted_q;
	logic [31:0]      m_window_q;
	logic [31:0]      m_last_q;

	result_t          result_q;
	logic             done_q;

	logic             scan_match, scan_free;

	assign stat.scan_last = (scan_idx_q == IDX_W'(TABLE_SLOTS - 1));

	assign scan_match = enabled_q[scan_idx_q] && (line_q[scan_idx_q] == item_q.line_mask);
	assign scan_free  = !enabled_q[scan_idx_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q     <= item;
			scan_idx_q <= '0;
		end else if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
		if (cmd.scan && scan_match && !match_hit_q) begin
			match_idx_q <= scan_idx_q;
			m_handler_q <= handler_q[scan_idx_q];
			m_lvl_chk_q <= lvl_chk_q[scan_idx_q];
			m_wanted_q  <= wanted_q[scan_idx_q];
			m_window_q  <= window_q[scan_idx_q];
			m_last_q    <= last_q[scan_idx_q];
		end
		if (cmd.scan && scan_free && !free_hit_q) begin
			free_idx_q <= scan_idx_q;
		end
	end

	// Hit flags are control state: the lowest hit of the scan wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
		end else if (cmd.load) begin
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
		end else if (cmd.scan) begin
			match_hit_q <= match_hit_q | scan_match;
			free_hit_q  <= free_hit_q | scan_free;
		end
	end

	// Execution of the command once the scan is complete.
	logic             wr_any;
	logic [IDX_W-1:0] wr_idx;
	logic             wr_line_en, wr_en_en, wr_hdl_en, wr_cfg_en, wr_last_en;
	logic [15:0]      wr_line;
	logic             wr_en_val;
	logic [7:0]       wr_hdl;
	logic [31:0]      wr_last;
	logic [31:0]      elapsed;
	logic             touched;
	logic [IDX_W-1:0] res_idx;
	logic [IDX_W+SLOT_INDEX_W-1:0] res_idx_ext;
	result_t          res_d;

	assign elapsed = item_q.now_us - m_last_q;

	always_comb begin
		wr_any     = 1'b0;
		wr_idx     = match_idx_q;
		wr_line_en = 1'b0;
		wr_en_en   = 1'b0;
		wr_hdl_en  = 1'b0;
		wr_cfg_en  = 1'b0;
		wr_last_en = 1'b0;
		wr_line    = item_q.line_mask;
		wr_en_val  = 1'b1;
		wr_hdl     = item_q.handler_id;
		wr_last    = '0;
		touched    = 1'b0;
		res_idx    = match_idx_q;
		res_d      = '0;
		res_d.status = ST_OK;
		unique case (item_q.command)
			CMD_REGISTER: begin
				if (item_q.handler_id == 8'd0) begin
					res_d.status = ST_NO_HANDLER;
				end else if (match_hit_q) begin
					wr_any     = 1'b1;
					wr_hdl_en  = 1'b1;
					wr_cfg_en  = 1'b1;
					wr_last_en = 1'b1;
					touched    = 1'b1;
				end else if (free_hit_q) begin
					wr_any     = 1'b1;
					wr_idx     = free_idx_q;
					wr_line_en = 1'b1;
					wr_en_en   = 1'b1;
					wr_hdl_en  = 1'b1;
					wr_cfg_en  = 1'b1;
					wr_last_en = 1'b1;
					touched    = 1'b1;
					res_idx    = free_idx_q;
				end else begin
					res_d.status = ST_FULL;
				end
			end
			CMD_UNREGISTER: begin
				if (match_hit_q) begin
					wr_any     = 1'b1;
					wr_line_en = 1'b1;
					wr_line    = '0;
					wr_en_en   = 1'b1;
					wr_en_val  = 1'b0;
					wr_hdl_en  = 1'b1;
					wr_hdl     = '0;
					touched    = 1'b1;
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			CMD_SET_ENABLE: begin
				if (match_hit_q) begin
					wr_any    = 1'b1;
					wr_en_en  = 1'b1;
					wr_en_val = item_q.turn_on;
					touched   = 1'b1;
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			CMD_EVENT: begin
				if (!match_hit_q || m_handler_q == 8'd0) begin
					res_d.status = ST_NOT_FOUND;
				end else if (m_lvl_chk_q && !m_wanted_q[1] &&
				             item_q.sampled_level != m_wanted_q[0]) begin
					res_d.status = ST_LEVEL;
					touched      = 1'b1;
				end else if (m_window_q != 32'd0 && elapsed < m_window_q) begin
					res_d.status = ST_DEBOUNCED;
					touched      = 1'b1;
				end else begin
					touched             = 1'b1;
					wr_any              = (m_window_q != 32'd0);
					wr_last_en          = (m_window_q != 32'd0);
					wr_last             = item_q.now_us;
					res_d.fire          = 1'b1;
					res_d.fired_handler = m_handler_q;
					res_d.fired_line    = item_q.line_mask;
				end
			end
			default: begin
				res_d.status = ST_NOT_FOUND;
			end
		endcase
		if (!touched) begin
			res_idx = '0;
		end
		res_idx_ext      = (IDX_W + SLOT_INDEX_W)'(res_idx);
		res_d.slot_index = res_idx_ext[SLOT_INDEX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_any) begin
			if (wr_line_en) begin
				line_q[wr_idx] <= wr_line;
			end
			if (wr_hdl_en) begin
				handler_q[wr_idx] <= wr_hdl;
			end
			if (wr_cfg_en) begin
				lvl_chk_q[wr_idx] <= item_q.level_checked;
				wanted_q[wr_idx]  <= item_q.wanted_level;
				window_q[wr_idx]  <= item_q.window_us;
			end
			if (wr_last_en) begin
				last_q[wr_idx] <= wr_last;
			end
		end
		if (cmd.exec) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec && wr_any && wr_en_en) begin
				enabled_q[wr_idx] <= wr_en_val;
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

>>> design/gpio_irq_dispatch_debounce_table.sv
// GPIO interrupt dispatch table with per-slot debounce, top level.
// A command beat taken at start (with busy low) yields its result beat, strobed by done, once
// the scan, which reads one slot per cycle, and the execute state are through; busy stays high
// until then, so a new command is taken only after the last. The receiver cannot stall results.
// Reset (arst_n low, asynchronous) disables every slot and returns the controller to idle.
`timescale 1ns / 1ps

module gpio_irq_dispatch_debounce_table #(
	parameter int TABLE_SLOTS = gidt_pkg::TABLE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gidt_pkg::item_t   item,
	output gidt_pkg::result_t result,
	output logic             done
);
	import gidt_pkg::*;

	// The controller walks IDLE -> SCAN -> EXEC. In SCAN the datapath looks at one slot a
	// cycle, remembering the lowest enabled slot whose line equals the command's line and
	// the lowest disabled slot. In EXEC the command acts on the remembered slot and the
	// result beat is registered; done pulses in the following cycle, while the controller
	// is already idle and can take the next command.
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	gidt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy)
	);

	// The datapath holds the slot table; a slot only becomes visible to matching once a
	// register command has written all of its fields, so only the enable bits are reset.
	gidt_datapath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.item   (item),
		.result (result),
		.done   (done)
	);

endmodule
